@@ hdl/gar_pkg.sv @@
`default_nettype none

package gar_pkg;

    // Largest rectangle side handled by default.
    localparam int MAX_DIM_DEFAULT = 4096;

    // Number of color channels and bits per channel.
    localparam int NUM_CH = 3;
    localparam int CH_W   = 8;

    // Pixel index width.
    localparam int IDX_W = 24;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // One pixel as classified by the front.
    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] old_color;   // blue in lane 0, red in lane 2
        logic [IDX_W-1:0]            pixel_index;
        logic                        last_pixel;
        logic                        row_start;   // first pixel of a row
        logic                        frame_start; // first pixel of the rectangle
    } t_pix_item;

endpackage

`default_nettype wire

@@ hdl/gar_grad_div.sv @@
`default_nettype none

// Per-channel step divider: |end - start| / height, one quotient bit per cycle
// on all three channels in parallel.
module gar_grad_div #(
    parameter int MAX_DIM = gar_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_start,
    input  wire logic [gar_pkg::NUM_CH-1:0][gar_pkg::CH_W-1:0] i_dvd,
    input  wire logic [$clog2(MAX_DIM):0]                      i_divisor,
    output logic                                               o_busy,
    output logic [gar_pkg::NUM_CH-1:0][gar_pkg::CH_W-1:0]      o_quo,
    output logic [gar_pkg::NUM_CH-1:0][$clog2(MAX_DIM):0]      o_rem
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int RW    = CW + 1;
    localparam int CNT_W = $clog2(gar_pkg::CH_W + 1);

    logic [CNT_W-1:0]                                 r_cnt;
    logic [gar_pkg::NUM_CH-1:0][gar_pkg::CH_W-1:0]    r_dvd;
    logic [gar_pkg::NUM_CH-1:0][gar_pkg::CH_W-1:0]    r_quo;
    logic [gar_pkg::NUM_CH-1:0][RW-1:0]               r_rem;
    logic [gar_pkg::NUM_CH-1:0][RW-1:0]               n_rem;
    logic [gar_pkg::NUM_CH-1:0]                       n_bit;

    // One restoring step per channel. The remainder stays below the divisor,
    // so its top bit can be dropped when shifting.
    always_comb begin
        logic [RW-1:0] shifted;
        for (int ch = 0; ch < gar_pkg::NUM_CH; ch++) begin
            shifted   = {r_rem[ch][RW-2:0], r_dvd[ch][gar_pkg::CH_W-1]};
            n_bit[ch] = (shifted >= i_divisor);
            n_rem[ch] = n_bit[ch] ? (shifted - i_divisor) : shifted;
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(gar_pkg::CH_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Dividend, quotient and remainder registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dvd;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            for (int ch = 0; ch < gar_pkg::NUM_CH; ch++) begin
                r_dvd[ch] <= {r_dvd[ch][gar_pkg::CH_W-2:0], 1'b0};
                r_quo[ch] <= {r_quo[ch][gar_pkg::CH_W-2:0], n_bit[ch]};
                r_rem[ch] <= n_rem[ch];
            end
        end
    end

    assign o_busy = i_start || (r_cnt != '0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ hdl/gar_front.sv @@
`default_nettype none

// Front: accepts old pixels, walks the rectangle in raster order and tags each
// beat with its pixel index and row / rectangle position.
module gar_front #(
    parameter int MAX_DIM = gar_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_restart,
    input  wire logic                             i_hold,
    input  wire logic [12:0]                      i_view_width,
    input  wire logic [gar_pkg::IDX_W-1:0]        i_base,
    input  wire logic [$clog2(MAX_DIM)-1:0]       i_w_m1,
    input  wire logic [$clog2(MAX_DIM)-1:0]       i_h_m1,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [gar_pkg::CH_W-1:0]         i_old_blue,
    input  wire logic [gar_pkg::CH_W-1:0]         i_old_green,
    input  wire logic [gar_pkg::CH_W-1:0]         i_old_red,
    output logic                                  o_push,
    output gar_pkg::t_pix_item                    o_item,
    input  wire logic                             i_q_ready
);

    localparam int CW = $clog2(MAX_DIM);

    logic [CW-1:0]                 r_col;
    logic [CW-1:0]                 r_row;
    logic [gar_pkg::IDX_W-1:0]     r_row_base;
    logic [gar_pkg::IDX_W-1:0]     row_base;
    logic                          col_end;
    logic                          row_end;
    logic                          accept;

    assign o_in_ready = i_q_ready && !i_hold;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    // Classify the current position.
    assign row_base = (r_row == '0) ? i_base : r_row_base;
    assign col_end  = (r_col == i_w_m1);
    assign row_end  = (r_row == i_h_m1);

    always_comb begin
        o_item.old_color[0] = i_old_blue;
        o_item.old_color[1] = i_old_green;
        o_item.old_color[2] = i_old_red;
        o_item.pixel_index  = row_base + gar_pkg::IDX_W'(r_col);
        o_item.last_pixel   = col_end && row_end;
        o_item.row_start    = (r_col == '0);
        o_item.frame_start  = (r_col == '0) && (r_row == '0);
    end

    // Raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : (r_row + CW'(1));
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Start index of the next row.
    always_ff @(posedge i_clk) begin
        if (accept && col_end) begin
            r_row_base <= row_base + gar_pkg::IDX_W'(i_view_width);
        end
    end

endmodule

`default_nettype wire

@@ hdl/gar_queue.sv @@
`default_nettype none

// Small flop queue between the front and the back.
module gar_queue #(
    parameter int W     = $bits(gar_pkg::t_pix_item),
    parameter int DEPTH = gar_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [W-1:0]      o_data,
    input  wire logic         i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CNTW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != CNTW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : (r_wr + AW'(1));
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : (r_rd + AW'(1));
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gar_back.sv @@
`default_nettype none

// Back: tracks the row gradient incrementally, then blends the gradient color
// with the old pixel over a three-stage pipeline ending in the output register.
module gar_back #(
    parameter int MAX_DIM = gar_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_pop_valid,
    input  wire gar_pkg::t_pix_item                             i_item,
    output logic                                                o_pop_ready,
    input  wire logic [23:0]                                    i_start_color,
    input  wire logic [23:0]                                    i_end_color,
    input  wire logic [8:0]                                     i_alpha,
    input  wire logic [$clog2(MAX_DIM):0]                       i_height,
    input  wire logic [gar_pkg::NUM_CH-1:0][gar_pkg::CH_W-1:0]  i_step_quo,
    input  wire logic [gar_pkg::NUM_CH-1:0][$clog2(MAX_DIM):0]  i_step_rem,
    output logic                                                o_out_valid,
    input  wire logic                                           i_out_ready,
    output logic [gar_pkg::IDX_W-1:0]                           o_pixel_index,
    output logic [gar_pkg::CH_W-1:0]                            o_new_blue,
    output logic [gar_pkg::CH_W-1:0]                            o_new_green,
    output logic [gar_pkg::CH_W-1:0]                            o_new_red,
    output logic                                                o_last_pixel
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int RW = CW + 1;
    localparam int NC = gar_pkg::NUM_CH;
    localparam int CH = gar_pkg::CH_W;

    typedef logic [NC-1:0][CH-1:0] t_color;

    // Gradient state: quotient of the current row, quotient and remainder of
    // the next row.
    t_color                 r_qa_cur;
    t_color                 r_qa_nxt;
    logic [NC-1:0][RW-1:0]  r_rem_nxt;
    t_color                 adv_q;
    logic [NC-1:0][RW-1:0]  adv_rem;
    t_color                 qa_sel;
    t_color                 grad;

    // Pipeline registers.
    logic                       r1_valid;
    t_color                     r1_color;
    t_color                     r1_old;
    logic [gar_pkg::IDX_W-1:0]  r1_index;
    logic                       r1_last;
    logic                       r2_valid;
    t_color                     r2_new_part;
    t_color                     r2_old_part;
    logic [gar_pkg::IDX_W-1:0]  r2_index;
    logic                       r2_last;
    logic                       r3_valid;
    t_color                     r3_color;
    logic [gar_pkg::IDX_W-1:0]  r3_index;
    logic                       r3_last;

    logic                       en;
    logic                       fire;
    logic [8:0]                 inv_alpha;

    assign en          = !r3_valid || i_out_ready;
    assign o_pop_ready = en;
    assign fire        = i_pop_valid && en;
    assign inv_alpha   = 9'd256 - i_alpha;

    // Next-row advance and gradient color of the popped beat.
    always_comb begin
        logic [RW-1:0] sum;
        logic          wrap;
        logic [CH-1:0] s;
        logic [CH-1:0] e;
        for (int ch = 0; ch < NC; ch++) begin
            sum         = r_rem_nxt[ch] + i_step_rem[ch];
            wrap        = (sum >= i_height);
            adv_rem[ch] = wrap ? (sum - i_height) : sum;
            adv_q[ch]   = r_qa_nxt[ch] + i_step_quo[ch] + CH'(wrap);

            if (i_item.frame_start) begin
                qa_sel[ch] = '0;
            end else if (i_item.row_start) begin
                qa_sel[ch] = r_qa_nxt[ch];
            end else begin
                qa_sel[ch] = r_qa_cur[ch];
            end

            s = i_start_color[ch*CH +: CH];
            e = i_end_color[ch*CH +: CH];
            grad[ch] = (e < s) ? (s - qa_sel[ch]) : (s + qa_sel[ch]);
        end
    end

    // Gradient state update on each popped beat that starts the rectangle or a row.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (i_item.frame_start) begin
                r_qa_cur  <= '0;
                r_qa_nxt  <= i_step_quo;
                r_rem_nxt <= i_step_rem;
            end else if (i_item.row_start) begin
                r_qa_cur  <= r_qa_nxt;
                r_qa_nxt  <= adv_q;
                r_rem_nxt <= adv_rem;
            end
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_pop_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Payload: color, weighted terms, blended sum.
    always_ff @(posedge i_clk) begin
        logic [CH+8:0] p_new;
        logic [CH+8:0] p_old;
        if (en) begin
            r1_color <= grad;
            r1_old   <= i_item.old_color;
            r1_index <= i_item.pixel_index;
            r1_last  <= i_item.last_pixel;

            for (int ch = 0; ch < NC; ch++) begin
                p_new = (CH+9)'(r1_color[ch]) * (CH+9)'(i_alpha);
                p_old = (CH+9)'(r1_old[ch]) * (CH+9)'(inv_alpha);
                r2_new_part[ch] <= p_new[CH+7:8];
                r2_old_part[ch] <= p_old[CH+7:8];
            end
            r2_index <= r1_index;
            r2_last  <= r1_last;

            for (int ch = 0; ch < NC; ch++) begin
                r3_color[ch] <= r2_new_part[ch] + r2_old_part[ch];
            end
            r3_index <= r2_index;
            r3_last  <= r2_last;
        end
    end

    assign o_out_valid   = r3_valid;
    assign o_pixel_index = r3_index;
    assign o_new_blue    = r3_color[0];
    assign o_new_green   = r3_color[1];
    assign o_new_red     = r3_color[2];
    assign o_last_pixel  = r3_last;

endmodule

`default_nettype wire

@@ hdl/gradient_alpha_rect_fill.sv @@
`default_nettype none

// Alpha-blended vertical gradient rectangle fill. Feed the old pixels of the
// configured rectangle in raster order, one beat per pixel; each beat returns
// one beat with the pixel index, the blended color and a last-pixel flag.
// Throughput is one pixel per clock while the output is not stalled and the
// divider does not hold input off: the row gradient is stepped with one add
// and one compare-subtract per channel, and the blend is a three-stage
// pipeline. After reset and after every write to a defined register, input
// is held off while the per-channel step divider (one quotient bit per cycle)
// works out |end - start| / height. Registers may only be written while the
// block is idle; every write to a defined register restarts the walk at the
// top-left pixel, and a write to an unused index is ignored.
module gradient_alpha_rect_fill #(
    parameter int MAX_DIM = gar_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gar_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gar_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [7:0]                        i_old_blue,
    input  wire logic [7:0]                        i_old_green,
    input  wire logic [7:0]                        i_old_red,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [23:0]                            o_pixel_index,
    output logic [7:0]                             o_new_blue,
    output logic [7:0]                             o_new_green,
    output logic [7:0]                             o_new_red,
    output logic                                   o_last_pixel
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int RW = CW + 1;
    localparam int NC = gar_pkg::NUM_CH;
    localparam int CH = gar_pkg::CH_W;
    localparam int QW = $bits(gar_pkg::t_pix_item);

    // Register indexes.
    localparam logic [gar_pkg::CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 4'd0;
    localparam logic [gar_pkg::CFG_IDX_W-1:0] CFG_RECT_X      = 4'd1;
    localparam logic [gar_pkg::CFG_IDX_W-1:0] CFG_RECT_Y      = 4'd2;
    localparam logic [gar_pkg::CFG_IDX_W-1:0] CFG_RECT_W      = 4'd3;
    localparam logic [gar_pkg::CFG_IDX_W-1:0] CFG_RECT_H      = 4'd4;
    localparam logic [gar_pkg::CFG_IDX_W-1:0] CFG_START_COLOR = 4'd5;
    localparam logic [gar_pkg::CFG_IDX_W-1:0] CFG_END_COLOR   = 4'd6;
    localparam logic [gar_pkg::CFG_IDX_W-1:0] CFG_ALPHA       = 4'd7;

    logic [12:0] r_view_width;
    logic [11:0] r_rect_x;
    logic [11:0] r_rect_y;
    logic [12:0] r_rect_w;
    logic [12:0] r_rect_h;
    logic [23:0] r_start_color;
    logic [23:0] r_end_color;
    logic [8:0]  r_alpha;
    logic        r_kick;
    logic [gar_pkg::IDX_W-1:0] r_base;

    logic                           cfg_fire;
    logic                           cfg_hit;
    logic [31:0]                    w_m1_full;
    logic [31:0]                    h_m1_full;
    logic [CW-1:0]                  w_m1;
    logic [CW-1:0]                  h_m1;
    logic [RW-1:0]                  height;
    logic [8:0]                     alpha_eff;
    logic [NC-1:0][CH-1:0]          abs_diff;
    logic [NC-1:0][CH-1:0]          step_quo;
    logic [NC-1:0][RW-1:0]          step_rem;
    logic                           div_busy;
    logic [25:0]                    base_full;

    logic                           push;
    gar_pkg::t_pix_item             push_item;
    logic                           q_ready;
    logic                           q_valid;
    logic [QW-1:0]                  q_data;
    logic                           pop_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    // Only a write to a defined register restarts the walk.
    assign cfg_hit     = cfg_fire && (i_cfg_index <= CFG_ALPHA);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_width  <= 13'd640;
            r_rect_x      <= '0;
            r_rect_y      <= '0;
            r_rect_w      <= 13'd1;
            r_rect_h      <= 13'd1;
            r_start_color <= '0;
            r_end_color   <= '0;
            r_alpha       <= 9'd256;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                CFG_VIEW_WIDTH:  r_view_width  <= i_cfg_data[12:0];
                CFG_RECT_X:      r_rect_x      <= i_cfg_data[11:0];
                CFG_RECT_Y:      r_rect_y      <= i_cfg_data[11:0];
                CFG_RECT_W:      r_rect_w      <= i_cfg_data[12:0];
                CFG_RECT_H:      r_rect_h      <= i_cfg_data[12:0];
                CFG_START_COLOR: r_start_color <= i_cfg_data[23:0];
                CFG_END_COLOR:   r_end_color   <= i_cfg_data[23:0];
                CFG_ALPHA:       r_alpha       <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    // Kick the step divider after reset and after every write to a defined register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick <= 1'b1;
        end else begin
            r_kick <= cfg_hit;
        end
    end

    // Effective sizes: zero counts as one, oversize is clamped.
    always_comb begin
        if (r_rect_w == '0) begin
            w_m1_full = '0;
        end else if (32'(r_rect_w) > 32'(MAX_DIM)) begin
            w_m1_full = 32'(MAX_DIM - 1);
        end else begin
            w_m1_full = 32'(r_rect_w) - 32'd1;
        end
        if (r_rect_h == '0) begin
            h_m1_full = '0;
        end else if (32'(r_rect_h) > 32'(MAX_DIM)) begin
            h_m1_full = 32'(MAX_DIM - 1);
        end else begin
            h_m1_full = 32'(r_rect_h) - 32'd1;
        end
    end

    assign w_m1      = w_m1_full[CW-1:0];
    assign h_m1      = h_m1_full[CW-1:0];
    assign height    = {1'b0, h_m1} + RW'(1);
    assign alpha_eff = (r_alpha > 9'd256) ? 9'd256 : r_alpha;

    // Magnitude of the color span per channel.
    always_comb begin
        logic [CH-1:0] s;
        logic [CH-1:0] e;
        for (int ch = 0; ch < NC; ch++) begin
            s = r_start_color[ch*CH +: CH];
            e = r_end_color[ch*CH +: CH];
            abs_diff[ch] = (e >= s) ? (e - s) : (s - e);
        end
    end

    // Index of the top-left pixel.
    assign base_full = 26'(r_rect_y) * 26'(r_view_width) + 26'(r_rect_x);

    always_ff @(posedge i_clk) begin
        r_base <= base_full[gar_pkg::IDX_W-1:0];
    end

    gar_grad_div #(
        .MAX_DIM (MAX_DIM)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_kick),
        .i_dvd     (abs_diff),
        .i_divisor (height),
        .o_busy    (div_busy),
        .o_quo     (step_quo),
        .o_rem     (step_rem)
    );

    gar_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (cfg_hit),
        .i_hold       (div_busy),
        .i_view_width (r_view_width),
        .i_base       (r_base),
        .i_w_m1       (w_m1),
        .i_h_m1       (h_m1),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_old_blue   (i_old_blue),
        .i_old_green  (i_old_green),
        .i_old_red    (i_old_red),
        .o_push       (push),
        .o_item       (push_item),
        .i_q_ready    (q_ready)
    );

    gar_queue #(
        .W     (QW),
        .DEPTH (gar_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop_ready)
    );

    gar_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (q_valid),
        .i_item        (gar_pkg::t_pix_item'(q_data)),
        .o_pop_ready   (pop_ready),
        .i_start_color (r_start_color),
        .i_end_color   (r_end_color),
        .i_alpha       (alpha_eff),
        .i_height      (height),
        .i_step_quo    (step_quo),
        .i_step_rem    (step_rem),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_new_blue    (o_new_blue),
        .o_new_green   (o_new_green),
        .o_new_red     (o_new_red),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
module testbench;

    localparam int QUIET_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam int LONG_HOLD    = 120;

    // Register indexes of the configuration port.
    typedef enum logic [gar_pkg::CFG_IDX_W-1:0] {
        REG_VIEW_WIDTH  = 0,
        REG_RECT_X      = 1,
        REG_RECT_Y      = 2,
        REG_RECT_W      = 3,
        REG_RECT_H      = 4,
        REG_START_COLOR = 5,
        REG_END_COLOR   = 6,
        REG_ALPHA       = 7,
        REG_UNUSED      = 15
    } reg_idx_e;

    typedef enum logic {STEP_REG, STEP_PIX} step_kind_e;

    // One written pixel as it leaves the block.
    typedef struct packed {
        logic [23:0] index;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        last;
    } fill_px_t;

    // One row of the directed stimulus.
    typedef struct {
        step_kind_e  kind;
        reg_idx_e    idx;
        logic [23:0] data;
        logic [7:0]  old_b;
        logic [7:0]  old_g;
        logic [7:0]  old_r;
        bit          typed;
        fill_px_t    want;
    } dir_step_t;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [gar_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [gar_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                            i_in_valid  = 1'b0;
    logic [7:0]                      i_old_blue  = '0;
    logic [7:0]                      i_old_green = '0;
    logic [7:0]                      i_old_red   = '0;
    logic                            i_out_ready = 1'b0;
    logic                            o_cfg_ready;
    logic                            o_in_ready;
    logic                            o_out_valid;
    logic [23:0]                     o_pixel_index;
    logic [7:0]                      o_new_blue;
    logic [7:0]                      o_new_green;
    logic [7:0]                      o_new_red;
    logic                            o_last_pixel;

    // A typed-in expectation travels with the pixel beat it belongs to.
    logic     px_typed     = 1'b0;
    fill_px_t px_typed_exp = '0;

    // Shadow registers and walk position of the fill predictor.
    int unsigned reg_view_w = 640;
    int unsigned reg_x      = 0;
    int unsigned reg_y      = 0;
    int unsigned reg_w      = 1;
    int unsigned reg_h      = 1;
    int unsigned reg_start  = 0;
    int unsigned reg_end    = 0;
    int unsigned reg_alpha  = 256;
    int unsigned walk_col   = 0;
    int unsigned walk_row   = 0;

    fill_px_t    fill_px_due[$];
    int unsigned px_sent      = 0;
    int unsigned px_written   = 0;
    int          errors       = 0;
    int          quiet_cycles = 0;
    bit          cfg_open     = 1'b0;
    bit          tx_busy      = 1'b1;
    bit          rx_busy      = 1'b1;

    gradient_alpha_rect_fill dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_old_blue    (i_old_blue),
        .i_old_green   (i_old_green),
        .i_old_red     (i_old_red),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_new_blue    (o_new_blue),
        .o_new_green   (o_new_green),
        .o_new_red     (o_new_red),
        .o_last_pixel  (o_last_pixel)
    );

    always #4 i_clk = ~i_clk;

    // Zero size counts as one, anything above the limit as the limit.
    function automatic int unsigned eff_side(input int unsigned v);
        if (v == 0)
            return 1;
        if (v > gar_pkg::MAX_DIM_DEFAULT)
            return gar_pkg::MAX_DIM_DEFAULT;
        return v;
    endfunction

    function automatic int unsigned pick_extreme_side();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return gar_pkg::MAX_DIM_DEFAULT;
            default: return 8191;
        endcase
    endfunction

    // Computes the written pixel for one old pixel and steps the raster walk.
    function automatic fill_px_t predict_fill_pixel(input logic [7:0] ob, og, orr);
        int unsigned     w, h, a, gc;
        int              s, e, q;
        longint unsigned lin;
        logic [7:0]      old_ch [3];
        logic [7:0]      mix [3];
        fill_px_t        px;
        w = eff_side(reg_w);
        h = eff_side(reg_h);
        a = (reg_alpha > 256) ? 256 : reg_alpha;
        old_ch[0] = ob;
        old_ch[1] = og;
        old_ch[2] = orr;
        if (walk_col >= w)
            walk_col = 0;
        if (walk_row >= h)
            walk_row = 0;
        // Row color per channel, quotient truncated toward zero, then the blend.
        for (int ch = 0; ch < 3; ch++) begin
            s = int'((reg_start >> (8 * ch)) & 255);
            e = int'((reg_end >> (8 * ch)) & 255);
            q = ((e - s) * int'(walk_row)) / int'(h);
            gc = (s + q) & 255;
            mix[ch] = 8'((gc * a) / 256 + (old_ch[ch] * (256 - a)) / 256);
        end
        lin = (longint'(reg_y) + walk_row) * reg_view_w + reg_x + walk_col;
        px.index = lin[23:0];
        px.blue  = mix[0];
        px.green = mix[1];
        px.red   = mix[2];
        px.last  = (walk_col == w - 1) && (walk_row == h - 1);
        if (walk_col + 1 >= w) begin
            walk_col = 0;
            walk_row = (walk_row + 1 >= h) ? 0 : walk_row + 1;
        end else begin
            walk_col++;
        end
        return px;
    endfunction

    function automatic dir_step_t reg_step(input reg_idx_e idx, input logic [23:0] data);
        dir_step_t st;
        st = '{STEP_REG, idx, data, 8'h00, 8'h00, 8'h00, 1'b0, '0};
        return st;
    endfunction

    function automatic dir_step_t pix_step(input logic [7:0] b, g, r, input bit typed,
                                           input fill_px_t want);
        dir_step_t st;
        st = '{STEP_PIX, REG_VIEW_WIDTH, 24'h0, b, g, r, typed, want};
        return st;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Stops offering pixels and waits until every written pixel has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (px_written != px_sent)
            @(posedge i_clk);
    endtask

    // Register beats go out back to back; the first of a group waits for idle.
    task automatic reg_write(input reg_idx_e idx, input logic [23:0] data);
        if (!cfg_open) begin
            wait_drained();
            cfg_open = 1'b1;
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic send_pixel(input logic [7:0] b, g, r, input bit typed,
                              input fill_px_t want);
        int gap;
        gap = tx_busy ? $urandom_range(0, 17) : 0;
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_old_blue   <= b;
        i_old_green  <= g;
        i_old_red    <= r;
        px_typed     <= typed;
        px_typed_exp <= want;
        do @(posedge i_clk); while (!o_in_ready);
        px_sent++;
        if ($urandom_range(0, 49) == 0)
            tx_busy = !tx_busy;
    endtask

    // Scoreboard: shadow register writes, predict on input beats, check output beats.
    always @(posedge i_clk) begin : scoreboard
        fill_px_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_VIEW_WIDTH:  reg_view_w = i_cfg_data[12:0];
                    REG_RECT_X:      reg_x      = i_cfg_data[11:0];
                    REG_RECT_Y:      reg_y      = i_cfg_data[11:0];
                    REG_RECT_W:      reg_w      = i_cfg_data[12:0];
                    REG_RECT_H:      reg_h      = i_cfg_data[12:0];
                    REG_START_COLOR: reg_start  = i_cfg_data;
                    REG_END_COLOR:   reg_end    = i_cfg_data;
                    REG_ALPHA:       reg_alpha  = i_cfg_data[8:0];
                    default: ;
                endcase
                // Only a write to an existing register restarts the walk.
                if (i_cfg_index <= REG_ALPHA) begin
                    walk_col = 0;
                    walk_row = 0;
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = predict_fill_pixel(i_old_blue, i_old_green, i_old_red);
                fill_px_due.push_back(px_typed ? px_typed_exp : want);
            end
            if (o_out_valid && i_out_ready) begin
                px_written++;
                if (fill_px_due.size() == 0) begin
                    $display("%0t unexpected beat: expected none, actual index %0h",
                             $time, o_pixel_index);
                    errors++;
                end else begin
                    want = fill_px_due.pop_front();
                    check_field("pixel_index", want.index, o_pixel_index);
                    check_field("new_blue", want.blue, o_new_blue);
                    check_field("new_green", want.green, o_new_green);
                    check_field("new_red", want.red, o_new_red);
                    check_field("last_pixel", want.last, o_last_pixel);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output side: random stalls per beat, with two long hold-offs.
    initial begin : sink
        int stall;
        int beats;
        beats = 0;
        forever begin
            stall = rx_busy ? $urandom_range(0, 17) : 0;
            if (beats == 350 || beats == 1000)
                stall = LONG_HOLD;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            beats++;
            if ($urandom_range(0, 49) == 0)
                rx_busy = !rx_busy;
        end
    end

    // Input side: directed rows, then random rectangles until enough pixels went in.
    initial begin : stimulus
        dir_step_t   dir_steps[$];
        int unsigned w_raw, h_raw, area, n_items, rnd_items;
        int unsigned view_w, pos_x, pos_y, c_start, c_end, a_val;

        // After reset: a 1x1 black overwrite at pixel zero, repeated on wrap.
        dir_steps.push_back(pix_step(8'hFF, 8'hFF, 8'hFF, 1'b1,
                                     '{24'h0, 8'h00, 8'h00, 8'h00, 1'b1}));
        dir_steps.push_back(pix_step(8'h5A, 8'hA5, 8'h3C, 1'b1,
                                     '{24'h0, 8'h00, 8'h00, 8'h00, 1'b1}));
        // Alpha zero keeps the old pixel.
        dir_steps.push_back(reg_step(REG_START_COLOR, 24'hFFFFFF));
        dir_steps.push_back(reg_step(REG_END_COLOR, 24'hFFFFFF));
        dir_steps.push_back(reg_step(REG_ALPHA, 24'd0));
        dir_steps.push_back(pix_step(8'h12, 8'h34, 8'h56, 1'b1,
                                     '{24'h0, 8'h12, 8'h34, 8'h56, 1'b1}));
        // Full alpha and alpha above full both overwrite with the solid color.
        dir_steps.push_back(reg_step(REG_ALPHA, 24'd256));
        dir_steps.push_back(pix_step(8'h00, 8'h00, 8'h00, 1'b1,
                                     '{24'h0, 8'hFF, 8'hFF, 8'hFF, 1'b1}));
        dir_steps.push_back(reg_step(REG_ALPHA, 24'd511));
        dir_steps.push_back(pix_step(8'h00, 8'h80, 8'h01, 1'b1,
                                     '{24'h0, 8'hFF, 8'hFF, 8'hFF, 1'b1}));
        // Corner of the largest frame: the index wraps past 24 bits.
        dir_steps.push_back(reg_step(REG_VIEW_WIDTH, 24'd4096));
        dir_steps.push_back(reg_step(REG_RECT_X, 24'd4095));
        dir_steps.push_back(reg_step(REG_RECT_Y, 24'd4095));
        dir_steps.push_back(reg_step(REG_RECT_W, 24'd2));
        dir_steps.push_back(reg_step(REG_RECT_H, 24'd4));
        dir_steps.push_back(reg_step(REG_START_COLOR, 24'h000000));
        dir_steps.push_back(pix_step(8'hFF, 8'h00, 8'hFF, 1'b1,
                                     '{24'hFFFFFF, 8'h00, 8'h00, 8'h00, 1'b0}));
        for (int k = 0; k < 7; k++)
            dir_steps.push_back(pix_step(8'(k * 37), 8'hFF, 8'h00, 1'b0, '0));
        // Falling gradients with truncation toward zero, zero width, zero stride.
        dir_steps.push_back(reg_step(REG_START_COLOR, 24'hFF0080));
        dir_steps.push_back(reg_step(REG_END_COLOR, 24'h00FF00));
        dir_steps.push_back(reg_step(REG_ALPHA, 24'd128));
        dir_steps.push_back(reg_step(REG_RECT_W, 24'd0));
        dir_steps.push_back(reg_step(REG_RECT_H, 24'd3));
        dir_steps.push_back(reg_step(REG_VIEW_WIDTH, 24'd0));
        for (int k = 0; k < 3; k++)
            dir_steps.push_back(pix_step(8'hC3, 8'h3C, 8'hFF, 1'b0, '0));
        // Oversize width, zero height, then a write to an unused index mid-row.
        dir_steps.push_back(reg_step(REG_RECT_W, 24'd8191));
        dir_steps.push_back(reg_step(REG_RECT_H, 24'd0));
        dir_steps.push_back(pix_step(8'h01, 8'h02, 8'h04, 1'b0, '0));
        dir_steps.push_back(pix_step(8'h80, 8'h40, 8'h20, 1'b0, '0));
        dir_steps.push_back(reg_step(REG_UNUSED, 24'hFFFFFF));
        dir_steps.push_back(pix_step(8'h7F, 8'hFE, 8'hAA, 1'b0, '0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_steps[k]) begin
            if (dir_steps[k].kind == STEP_REG)
                reg_write(dir_steps[k].idx, dir_steps[k].data);
            else
                send_pixel(dir_steps[k].old_b, dir_steps[k].old_g, dir_steps[k].old_r,
                           dir_steps[k].typed, dir_steps[k].want);
        end

        // Random rectangles, mostly small ones walked to the end and wrapped.
        rnd_items = 0;
        while (rnd_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    w_raw = pick_extreme_side();
                    h_raw = $urandom_range(1, 3);
                    n_items = $urandom_range(3, 20);
                end
                1: begin
                    w_raw = $urandom_range(1, 2);
                    h_raw = $urandom_range(100, 300);
                    n_items = w_raw * h_raw + $urandom_range(0, 4);
                end
                2: begin
                    w_raw = $urandom_range(1, 4);
                    h_raw = pick_extreme_side();
                    n_items = $urandom_range(10, 60);
                end
                default: begin
                    w_raw = $urandom_range(1, 8);
                    h_raw = $urandom_range(1, 8);
                    area = eff_side(w_raw) * eff_side(h_raw);
                    n_items = area * $urandom_range(1, 3) + $urandom_range(0, area - 1);
                end
            endcase
            case ($urandom_range(0, 7))
                0: view_w = 0;
                1: view_w = 1;
                2: view_w = 4096;
                3: view_w = 8191;
                default: view_w = $urandom_range(1, 4096);
            endcase
            pos_x = ($urandom_range(0, 3) == 0) ? 4095 * $urandom_range(0, 1)
                                                : $urandom_range(0, 4095);
            pos_y = ($urandom_range(0, 3) == 0) ? 4095 * $urandom_range(0, 1)
                                                : $urandom_range(0, 4095);
            c_start = $urandom_range(0, 24'hFFFFFF);
            case ($urandom_range(0, 5))
                0: c_end = c_start;
                1: c_end = 0;
                2: c_end = 24'hFFFFFF;
                default: c_end = $urandom_range(0, 24'hFFFFFF);
            endcase
            case ($urandom_range(0, 5))
                0: a_val = 0;
                1: a_val = 256;
                2: a_val = $urandom_range(257, 511);
                default: a_val = $urandom_range(0, 256);
            endcase
            reg_write(REG_VIEW_WIDTH, 24'(view_w));
            reg_write(REG_RECT_X, 24'(pos_x));
            reg_write(REG_RECT_Y, 24'(pos_y));
            reg_write(REG_RECT_W, 24'(w_raw));
            reg_write(REG_RECT_H, 24'(h_raw));
            reg_write(REG_START_COLOR, 24'(c_start));
            reg_write(REG_END_COLOR, 24'(c_end));
            reg_write(REG_ALPHA, 24'(a_val));
            for (int unsigned k = 0; k < n_items && rnd_items < RANDOM_ITEMS; k++) begin
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
                rnd_items++;
                // Once, let the whole pipeline empty in the middle of a rectangle.
                if (rnd_items == RANDOM_ITEMS / 2)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fill_px_due.size() != 0) begin
            $display("%0t missing %0d beats: expected index %0h, actual none",
                     $time, fill_px_due.size(), fill_px_due[0].index);
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ gradient_alpha_rect_fill.f @@
hdl/gar_pkg.sv
hdl/gar_grad_div.sv
hdl/gar_front.sv
hdl/gar_queue.sv
hdl/gar_back.sv
hdl/gradient_alpha_rect_fill.sv
tb/sv/testbench.sv
